/* rtl/lse_pkg.sv */
// Shared types, codes and constants of the LED strip effect engine.
package lse_pkg;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_FILL   = 2'd2,
    OP_SINGLE = 2'd3
  } lse_op_t;

  // Effect selected by the effect_mode register
  typedef enum logic [1:0] {
    MODE_FWD_WAVE = 2'd0,
    MODE_BWD_WAVE = 2'd1,
    MODE_SNAKE    = 2'd2,
    MODE_METEOR   = 2'd3
  } lse_mode_t;

  localparam int COLOR_W   = 24;
  localparam int LED_NUM_W = 6;
  localparam int TARGET_W  = 8;
  localparam int PICK_W    = 3;

  localparam logic [3:0] FWD_SPAN          = 4'd10;
  localparam logic [5:0] SNAKE_HEAD_LEN    = 6'd10;
  localparam logic [5:0] METEOR_SPAN       = 6'd50;
  localparam logic [7:0] METEOR_FADE       = 8'd50;
  localparam logic [5:0] METEOR_FADE_STEPS = 6'd15;
  localparam logic [5:0] BWD_PERIOD_START  = 6'd5;

  // Meteor head palette, GRB
  localparam logic [COLOR_W-1:0] PALETTE [7] = '{
    24'hff0000, 24'h00ff00, 24'h0000ff, 24'hffff00,
    24'hff00ff, 24'h00ffff, 24'hffffff
  };

  // Tick request from the sequencer to the effect unit
  typedef struct packed {
    logic               commit;
    lse_mode_t          mode;
    logic [COLOR_W-1:0] rnd_color;
    logic [PICK_W-1:0]  pick;
  } lse_tick_req_t;

endpackage

/* rtl/lse_frame_ram.sv */
// Frame color memory: one write port, one registered read port, valid bits for reset.
module lse_frame_ram #(
  parameter int DEPTH = 60
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        we,
  input  logic [$clog2(DEPTH)-1:0]    waddr,
  input  logic [lse_pkg::COLOR_W-1:0] wdata,
  input  logic                        re,
  input  logic [$clog2(DEPTH)-1:0]    raddr,
  output logic [lse_pkg::COLOR_W-1:0] rdata
);

  logic [lse_pkg::COLOR_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            vld_r;
  logic [lse_pkg::COLOR_W-1:0] q_r;
  logic                        q_vld_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Mark written entries; unwritten entries read as dark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        q_vld_r <= vld_r[raddr];
      end
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      q_r <= mem[raddr];
    end
  end

  assign rdata = q_vld_r ? q_r : '0;

endmodule

/* rtl/lse_effect.sv */
// Effect unit: phase counters of the four effects and the new head color of a tick.
module lse_effect #(
  parameter int LED_COUNT = 60
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lse_pkg::lse_tick_req_t      req,
  input  logic [lse_pkg::COLOR_W-1:0] old_head,
  output logic [lse_pkg::COLOR_W-1:0] head_color,
  output logic                        shift_down
);

  localparam logic [7:0] TICK_WRAP = 8'(4 * LED_COUNT);
  localparam logic [5:0] LED_LAST  = 6'(LED_COUNT - 1);
  localparam logic [5:0] LED_CNT6  = 6'(LED_COUNT);

  logic [3:0] fwd_r, fwd_nxt;
  logic [7:0] bcnt_r, bcnt_nxt;
  logic [5:0] bper_r, bper_nxt;
  logic [5:0] bph_r, bph_nxt;
  logic [5:0] snk_r, snk_nxt;
  logic [5:0] met_r, met_nxt;
  logic       turn_r, turn_nxt;

  logic [7:0] bcnt1;
  logic       bwrap;
  logic [5:0] bper1, bper_w, bper_sel, bper_use, bph_use, bp;
  logic [2:0] pal_idx;
  logic [lse_pkg::COLOR_W-1:0] faded;

  function automatic logic [7:0] fade_ch(input logic [7:0] c);
    fade_ch = (c > lse_pkg::METEOR_FADE) ? c - lse_pkg::METEOR_FADE : c;
  endfunction

  // Backward wave period and phase after this tick's count update
  always_comb begin
    bcnt1    = bcnt_r + 8'd1;
    bwrap    = (bcnt1 >= TICK_WRAP);
    bper1    = bper_r + 6'd1;
    bper_w   = (bper1 == LED_CNT6 || bper1 == 6'd0) ? lse_pkg::BWD_PERIOD_START : bper1;
    bper_sel = bwrap ? bper_w : bper_r;
    bper_use = (bper_sel == 6'd0) ? lse_pkg::BWD_PERIOD_START : bper_sel;
    bph_use  = bwrap ? 6'd0 : bph_r;
    // phase never exceeds the period, so one subtract reduces it
    bp       = (bph_use >= bper_use) ? bph_use - bper_use : bph_use;
  end

  assign pal_idx = (req.pick == 3'd7) ? 3'd0 : req.pick;
  assign faded   = {fade_ch(old_head[23:16]), fade_ch(old_head[15:8]),
                    fade_ch(old_head[7:0])};
  assign shift_down = (req.mode == lse_pkg::MODE_BWD_WAVE);

  // Head color and counter updates of the selected effect
  always_comb begin
    fwd_nxt    = fwd_r;
    bcnt_nxt   = bcnt_r;
    bper_nxt   = bper_r;
    bph_nxt    = bph_r;
    snk_nxt    = snk_r;
    met_nxt    = met_r;
    turn_nxt   = turn_r;
    head_color = old_head;
    case (req.mode)
      lse_pkg::MODE_FWD_WAVE: begin
        if (fwd_r == 4'd0) begin
          head_color = req.rnd_color;
        end
        fwd_nxt = (fwd_r == lse_pkg::FWD_SPAN - 4'd1) ? 4'd0 : fwd_r + 4'd1;
      end
      lse_pkg::MODE_BWD_WAVE: begin
        if (bp == 6'd0) begin
          head_color = req.rnd_color;
        end
        bcnt_nxt = bwrap ? 8'd0 : bcnt1;
        bper_nxt = bper_use;
        bph_nxt  = bp + 6'd1;
      end
      lse_pkg::MODE_SNAKE: begin
        if (snk_r == 6'd0) begin
          head_color = req.rnd_color;
        end else if (snk_r >= lse_pkg::SNAKE_HEAD_LEN) begin
          head_color = '0;
        end
        snk_nxt = (snk_r == LED_LAST) ? 6'd0 : snk_r + 6'd1;
      end
      lse_pkg::MODE_METEOR: begin
        if (met_r == 6'd0) begin
          head_color = turn_r ? req.rnd_color : lse_pkg::PALETTE[pal_idx];
          turn_nxt   = ~turn_r;
        end else if (met_r <= lse_pkg::METEOR_FADE_STEPS) begin
          head_color = faded;
        end else begin
          head_color = '0;
        end
        met_nxt = (met_r == lse_pkg::METEOR_SPAN - 6'd1) ? 6'd0 : met_r + 6'd1;
      end
      default: begin
        head_color = old_head;
      end
    endcase
  end

  // Commit counters on a tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r  <= 4'd0;
      bcnt_r <= 8'd0;
      bper_r <= lse_pkg::BWD_PERIOD_START;
      bph_r  <= 6'd0;
      snk_r  <= 6'd0;
      met_r  <= 6'd0;
      turn_r <= 1'b0;
    end else if (req.commit) begin
      fwd_r  <= fwd_nxt;
      bcnt_r <= bcnt_nxt;
      bper_r <= bper_nxt;
      bph_r  <= bph_nxt;
      snk_r  <= snk_nxt;
      met_r  <= met_nxt;
      turn_r <= turn_nxt;
    end
  end

endmodule

/* rtl/led_strip_effect_engine.sv */
// Flow: a fill, clear or single-LED item goes from accept to S_SWEEP and then to the registered
// output; a tick passes S_HEAD_RD and S_HEAD_WR first (read old head, write new head); then one
// LED result per cycle while the output is not stalled. Items do not overlap: in_tready stays low
// until the single read port of the frame RAM has swept every LED of the strip.
// Reset (synchronous rst_n): counters return to their start values, ring base and effect_mode clear;
// the frame reads dark through per-entry valid bits, so no clearing pass is needed.
module led_strip_effect_engine #(
  parameter int LED_COUNT = 60
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: fill_color[23:0], target_index[31:24], rand_grb[55:32],
  //           random_pick[58:56], zero pad [63:59]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  // in_tuser: opcode[1:0]
  input  logic [1:0]  in_tuser,
  // out_tdata: led_number[5:0], led_color[29:6], zero pad [31:30]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // out_tlast: frame_end
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = $clog2(LED_COUNT);
  localparam logic [AW-1:0] LAST_IDX = AW'(LED_COUNT - 1);
  localparam logic [AW:0]   CNT_EXT  = (AW + 1)'(LED_COUNT);
  localparam logic          REG_EFFECT_MODE = 1'b0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HEAD_RD,
    S_HEAD_WR,
    S_SWEEP
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] mode_r;

  // Latched item
  lse_pkg::lse_op_t          op_r, op_nxt;
  logic [lse_pkg::COLOR_W-1:0]  fill_r, fill_nxt;
  logic [lse_pkg::TARGET_W-1:0] tgt_r, tgt_nxt;
  logic [lse_pkg::COLOR_W-1:0]  rnd_r, rnd_nxt;
  logic [lse_pkg::PICK_W-1:0]   pick_r, pick_nxt;

  // Sweep and ring pointer
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [AW-1:0] base_m1, base_p1, phys;
  logic [AW:0]   sum;

  // Output stage (color comes from the RAM read register or an override)
  logic                        out_tvalid_r, out_tvalid_nxt;
  logic [AW-1:0]               num_r, num_nxt;
  logic                        last_r, last_nxt;
  logic                        ovr_r, ovr_nxt;
  logic [lse_pkg::COLOR_W-1:0] ovr_col_r, ovr_col_nxt;

  // RAM ports
  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [lse_pkg::COLOR_W-1:0] ram_wdata, ram_rdata;

  lse_pkg::lse_tick_req_t      tick_req;
  logic [lse_pkg::COLOR_W-1:0] head_color;
  logic                        shift_down;
  logic                        port_free;
  logic                        cfg_wr;

  lse_frame_ram #(.DEPTH(LED_COUNT)) u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lse_effect #(.LED_COUNT(LED_COUNT)) u_effect (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (tick_req),
    .old_head   (ram_rdata),
    .head_color (head_color),
    .shift_down (shift_down)
  );

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_EFFECT_MODE) ? {30'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 2'd0;
    end else if (cfg_wr && cfg_paddr[2] == REG_EFFECT_MODE) begin
      mode_r <= cfg_pwdata[1:0];
    end
  end

  // Ring neighbors and logical-to-physical mapping
  assign base_m1 = (base_r == '0) ? LAST_IDX : base_r - AW'(1);
  assign base_p1 = (base_r == LAST_IDX) ? '0 : base_r + AW'(1);
  assign sum     = {1'b0, base_r} + {1'b0, idx_r};
  assign phys    = (sum >= CNT_EXT) ? AW'(sum - CNT_EXT) : sum[AW-1:0];

  assign port_free = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    fill_nxt       = fill_r;
    tgt_nxt        = tgt_r;
    rnd_nxt        = rnd_r;
    pick_nxt       = pick_r;
    idx_nxt        = idx_r;
    base_nxt       = base_r;
    out_tvalid_nxt = out_tready ? 1'b0 : out_tvalid_r;
    num_nxt        = num_r;
    last_nxt       = last_r;
    ovr_nxt        = ovr_r;
    ovr_col_nxt    = ovr_col_r;
    ram_we         = 1'b0;
    ram_waddr      = base_r;
    ram_wdata      = head_color;
    ram_re         = 1'b0;
    ram_raddr      = phys;
    tick_req.commit    = 1'b0;
    tick_req.mode      = lse_pkg::lse_mode_t'(mode_r);
    tick_req.rnd_color = rnd_r;
    tick_req.pick      = pick_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = lse_pkg::lse_op_t'(in_tuser);
          fill_nxt  = in_tdata[23:0];
          tgt_nxt   = in_tdata[31:24];
          rnd_nxt   = in_tdata[55:32];
          pick_nxt  = in_tdata[58:56];
          idx_nxt   = '0;
          state_nxt = (lse_pkg::lse_op_t'(in_tuser) == lse_pkg::OP_TICK) ? S_HEAD_RD
                                                                        : S_SWEEP;
        end
      end
      S_HEAD_RD: begin
        // read the current head once the read register is free
        if (port_free) begin
          ram_re    = 1'b1;
          ram_raddr = shift_down ? base_m1 : base_r;
          state_nxt = S_HEAD_WR;
        end
      end
      S_HEAD_WR: begin
        // write the new head and rotate the ring
        ram_we          = 1'b1;
        ram_waddr       = shift_down ? base_r : base_m1;
        ram_wdata       = head_color;
        tick_req.commit = 1'b1;
        base_nxt        = shift_down ? base_p1 : base_m1;
        state_nxt       = S_SWEEP;
      end
      S_SWEEP: begin
        if (port_free) begin
          ram_re         = 1'b1;
          ram_raddr      = phys;
          out_tvalid_nxt = 1'b1;
          num_nxt        = idx_r;
          last_nxt       = (idx_r == LAST_IDX);
          case (op_r)
            lse_pkg::OP_CLEAR: begin
              ovr_nxt     = 1'b1;
              ovr_col_nxt = '0;
            end
            lse_pkg::OP_FILL: begin
              ovr_nxt     = 1'b1;
              ovr_col_nxt = fill_r;
            end
            lse_pkg::OP_SINGLE: begin
              ovr_nxt     = (tgt_r < lse_pkg::TARGET_W'(LED_COUNT));
              ovr_col_nxt = (lse_pkg::TARGET_W'(idx_r) == tgt_r) ? fill_r : '0;
            end
            default: begin
              ovr_nxt     = 1'b0;
              ovr_col_nxt = '0;
            end
          endcase
          ram_we    = ovr_nxt;
          ram_waddr = phys;
          ram_wdata = ovr_col_nxt;
          if (idx_r == LAST_IDX) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      base_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      base_r       <= base_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    fill_r    <= fill_nxt;
    tgt_r     <= tgt_nxt;
    rnd_r     <= rnd_nxt;
    pick_r    <= pick_nxt;
    num_r     <= num_nxt;
    last_r    <= last_nxt;
    ovr_r     <= ovr_nxt;
    ovr_col_r <= ovr_col_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {2'b00, (ovr_r ? ovr_col_r : ram_rdata),
                       lse_pkg::LED_NUM_W'(num_r)};

  // Ring base and sweep index stay inside the strip
  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    base_r < AW'(LED_COUNT - 1) || base_r == LAST_IDX)
    else $error("ring base out of range");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r < AW'(LED_COUNT - 1) || idx_r == LAST_IDX)
    else $error("sweep index out of range");

  // The head read must not overwrite a result still waiting at the output
  a_head_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HEAD_WR |-> !out_tvalid_r)
    else $error("head read clobbered a pending result");

  // Frame end marks the last LED only
  a_last_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> num_r == LAST_IDX)
    else $error("frame end on wrong LED");

endmodule
